// ----- rtl/core/cna_pkg.sv -----
package cna_pkg;

  // Identifier space
  localparam int unsigned NUM_W      = 15;
  localparam int unsigned MAX_NUMBER = 32767;

  // Bitmap organization: one used mark per bit, WORD_W marks per memory row
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OFF_W  = $clog2(WORD_W);
  localparam int unsigned ADDR_W = NUM_W - OFF_W;
  localparam int unsigned WORDS  = 2 ** ADDR_W;

  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [ADDR_W-1:0] waddr_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    num_t    number;
  } cmd_t;

  typedef struct packed {
    num_t granted;
    logic exhausted;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_REL
  } state_t;

  // Which bits of the current row take part in the search
  typedef enum logic [1:0] {
    SCAN_ALL,
    SCAN_UPPER,
    SCAN_LOWER
  } scan_mode_t;

  typedef struct packed {
    word_t      bits;
    waddr_t     addr;
    off_t       off;
    scan_mode_t mode;
  } scan_req_t;

  typedef struct packed {
    logic found;
    off_t bit_idx;
  } scan_rsp_t;

endpackage

// ----- rtl/core/call_number_allocator.sv -----
// Next-fit identifier allocator. Hands out identifiers 1..MAX_NUMBER from a
// bitmap of used marks kept in a 1024 x 32 memory, and takes them back.
// Pulse start for one cycle while busy is low with cmd.action = allocate or
// release; exactly one result word follows, shown on result for the single
// cycle in which done is high. The receiver cannot stall: capture result
// whenever done is high. An allocate advances the rotating pointer by one
// (wrapping to 1), then scans rows of the bitmap from that point onward,
// wrapping around, one row per cycle through a single 32-bit free-bit
// search. When the map is full the result is granted = 0, exhausted = 1.
// A release is a read-modify-write of one row; a release of 0 touches no
// row. The next command may be issued in the cycle done is high. After
// reset the block runs a clearing pass over the memory with busy high. A
// write on cfg_we loads cfg_wdata into the rotating pointer; write it only
// while busy is low.
module call_number_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cna_pkg::cmd_t       cmd,
  output logic                done,
  output cna_pkg::res_t       result,
  input  logic                cfg_we,
  input  cna_pkg::num_t       cfg_wdata
);
  import cna_pkg::*;

  // Sequencer state
  state_t state, state_next;

  // Clearing pass row counter
  waddr_t clr_cnt, clr_cnt_next;

  // Rotating search pointer and scan context
  num_t   ptr, ptr_next;
  waddr_t cur_word, cur_word_next;   // row whose data arrives this cycle
  waddr_t start_word, start_word_next;
  off_t   start_off, start_off_next;
  logic   wrapped, wrapped_next;     // left the start row once already
  off_t   rel_off, rel_off_next;

  // Registered result word
  logic done_next;
  res_t result_next;

  // Bitmap memory: one write port, one registered read port
  word_t  mem [WORDS];
  word_t  rdata;
  logic   mem_we;
  waddr_t mem_waddr;
  word_t  mem_wdata;
  waddr_t mem_raddr;

  // Shared row search unit
  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  // Advanced pointer for an allocate, wrapping past MAX_NUMBER to 1
  logic [NUM_W:0] ptr_inc;
  num_t           alloc_ptr;
  logic           at_start_row;
  logic           accept;

  assign busy    = rst || (state != ST_IDLE);
  assign accept  = start && !busy;
  assign ptr_inc = {1'b0, ptr} + (NUM_W + 1)'(1);
  assign alloc_ptr = (ptr_inc > (NUM_W + 1)'(MAX_NUMBER)) ? num_t'(1)
                                                          : ptr_inc[NUM_W-1:0];
  assign at_start_row = (cur_word == start_word);

  always_comb begin
    scan_req.bits = rdata;
    scan_req.addr = cur_word;
    scan_req.off  = start_off;
    if (at_start_row && !wrapped) begin
      scan_req.mode = SCAN_UPPER;      // first visit: pointer and above
    end else if (at_start_row) begin
      scan_req.mode = SCAN_LOWER;      // back around: below the pointer
    end else begin
      scan_req.mode = SCAN_ALL;
    end
  end

  cna_word_scan u_scan (
    .req (scan_req),
    .rsp (scan_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == waddr_t'(WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_ALLOC) begin
            state_next = ST_EVAL;
          end else if (cmd.number != '0) begin
            state_next = ST_REL;
          end
        end
      end
      ST_EVAL: begin
        if (scan_rsp.found || (at_start_row && wrapped)) state_next = ST_IDLE;
      end
      ST_REL: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    clr_cnt_next    = clr_cnt;
    ptr_next        = ptr;
    cur_word_next   = cur_word;
    start_word_next = start_word;
    start_off_next  = start_off;
    wrapped_next    = wrapped;
    rel_off_next    = rel_off;
    done_next       = 1'b0;
    result_next     = result;
    mem_we          = 1'b0;
    mem_waddr       = cur_word;
    mem_wdata       = rdata;
    mem_raddr       = cur_word;

    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt + waddr_t'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_ALLOC) begin
            ptr_next        = alloc_ptr;
            cur_word_next   = alloc_ptr[NUM_W-1:OFF_W];
            start_word_next = alloc_ptr[NUM_W-1:OFF_W];
            start_off_next  = alloc_ptr[OFF_W-1:0];
            wrapped_next    = 1'b0;
            mem_raddr       = alloc_ptr[NUM_W-1:OFF_W];
          end else if (cmd.number != '0) begin
            cur_word_next = cmd.number[NUM_W-1:OFF_W];
            rel_off_next  = cmd.number[OFF_W-1:0];
            mem_raddr     = cmd.number[NUM_W-1:OFF_W];
          end else begin
            // release of zero: nothing to touch
            done_next   = 1'b1;
            result_next = '0;
          end
        end
      end
      ST_EVAL: begin
        if (scan_rsp.found) begin
          mem_we      = 1'b1;
          mem_waddr   = cur_word;
          mem_wdata   = rdata | (word_t'(1) << scan_rsp.bit_idx);
          done_next   = 1'b1;
          result_next = '{granted: {cur_word, scan_rsp.bit_idx}, exhausted: 1'b0};
        end else if (at_start_row && wrapped) begin
          done_next   = 1'b1;
          result_next = '{granted: '0, exhausted: 1'b1};
        end else begin
          // fetch the next row, data lands next cycle
          cur_word_next = cur_word + waddr_t'(1);
          mem_raddr     = cur_word + waddr_t'(1);
          wrapped_next  = 1'b1;
        end
      end
      ST_REL: begin
        mem_we      = 1'b1;
        mem_waddr   = cur_word;
        mem_wdata   = rdata & ~(word_t'(1) << rel_off);
        done_next   = 1'b1;
        result_next = '0;
      end
      default: ;
    endcase

    if (cfg_we) ptr_next = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      ptr     <= num_t'(1);
      wrapped <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      ptr     <= ptr_next;
      wrapped <= wrapped_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_word   <= cur_word_next;
    start_word <= start_word_next;
    start_off  <= start_off_next;
    rel_off    <= rel_off_next;
    result     <= result_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // An accepted allocate always enters the search
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.action == ACT_ALLOC) |=> (state == ST_EVAL))
    else $error("allocate not started");

  // Consecutive search cycles step through rows one at a time
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && $past(state) == ST_EVAL) |->
      (cur_word == $past(cur_word) + waddr_t'(1)))
    else $error("row scan skipped");

  // A failed search never reports a granted identifier
  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.exhausted) |-> (result.granted == '0))
    else $error("exhausted with nonzero grant");

  // A granted identifier is always in the legal range
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.granted != '0) |-> (result.granted <= num_t'(MAX_NUMBER)))
    else $error("grant out of range");

endmodule

// ----- rtl/core/cna_word_scan.sv -----
module cna_word_scan (
  input  cna_pkg::scan_req_t req,
  output cna_pkg::scan_rsp_t rsp
);
  import cna_pkg::*;

  num_t num;
  logic in_range;
  logic keep;

  // Lowest free, in-range, unmasked bit of one row
  always_comb begin
    rsp      = '0;
    num      = '0;
    in_range = 1'b0;
    keep     = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      num      = {req.addr, off_t'(b)};
      in_range = (num != '0) && (num <= num_t'(MAX_NUMBER));
      case (req.mode)
        SCAN_UPPER: keep = (off_t'(b) >= req.off);
        SCAN_LOWER: keep = (off_t'(b) < req.off);
        default:    keep = 1'b1;
      endcase
      if (!req.bits[b] && in_range && keep) begin
        rsp.found   = 1'b1;
        rsp.bit_idx = off_t'(b);
      end
    end
  end

endmodule

// ----- tb/alloc_checker.sv -----
`timescale 1ns / 100ps

module alloc_checker
  import cna_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd,
  input  logic done,
  input  res_t result,
  input  logic cfg_we,
  input  num_t cfg_wdata,
  output int   errors,
  output int   pending
);

  bit   id_used [MAX_NUMBER + 1];
  num_t scan_ptr;
  res_t owed_results [$];
  int   mismatches = 0;
  int   owed = 0;

  assign errors  = mismatches;
  assign pending = owed;

  // Bump the pointer, search from it to the top, then wrap to 1.
  // The pointer stays where it was bumped to, not on the grant.
  function automatic res_t next_fit_grant();
    int unsigned from_id;
    int unsigned id;
    int          n;
    res_t        r;
    from_id = int'(scan_ptr) + 1;
    if (from_id > MAX_NUMBER) from_id = 1;
    scan_ptr = num_t'(from_id);
    r = '0;
    for (n = 0; n < MAX_NUMBER; n++) begin
      id = from_id + n;
      if (id > MAX_NUMBER) id = id - MAX_NUMBER;
      if (!id_used[id]) begin
        id_used[id] = 1'b1;
        r.granted = num_t'(id);
        return r;
      end
    end
    r.exhausted = 1'b1;
    return r;
  endfunction

  task automatic report(input string field, input int want_v, input int got_v);
    if (mismatches < 40)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      id_used = '{default: 1'b0};
      scan_ptr = num_t'(1);
      owed_results.delete();
    end else begin
      // result first: a new word may be taken in the cycle done is high
      if (done) begin
        if (owed_results.size() == 0) begin
          if (mismatches < 40)
            $display("%0t: unexpected result: expected none, actual granted %0d exhausted %0d",
                     $time, result.granted, result.exhausted);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (result.granted !== want.granted)
            report("granted", want.granted, result.granted);
          if (result.exhausted !== want.exhausted)
            report("exhausted", want.exhausted, result.exhausted);
        end
      end
      if (cfg_we) scan_ptr = cfg_wdata;
      if (start && !busy) begin
        if (cmd.action == ACT_ALLOC) begin
          want = next_fit_grant();
        end else begin
          if (cmd.number != '0) id_used[cmd.number] = 1'b0;
          want = '0;
        end
        owed_results.push_back(want);
      end
    end
    owed = owed_results.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import cna_pkg::*;

  // Longest legal stretch with no word moving is a full-map scan or the
  // clearing pass after reset; sender gaps are short.
  localparam int QUIET_LIMIT = 20000;
  // A full-map scan is the slowest thing the block does; wait this long at
  // the end for any stray result.
  localparam int TAIL_CYCLES = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic cfg_we = 1'b0;
  num_t cfg_wdata = '0;

  logic busy;
  logic done;
  res_t result;
  int   errors;
  int   pending;

  // Percent chance, per cycle, that the sender holds back before a word.
  int   idle_pct = 0;
  // Ids seen granted; releases are mostly drawn from here so they hit used marks.
  num_t held_ids [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  call_number_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  alloc_checker chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // Sampled mid-cycle so the stimulus side never races the capture.
  always @(negedge clk) begin
    if (done && result.granted != '0) held_ids.push_back(result.granted);
  end

  // Present one word and hold it until the block takes it (start high,
  // busy low at the edge). start stays high on return so back-to-back
  // words follow without a gap.
  task automatic send_word(input action_t act, input num_t num);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd   <= cmd_t'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{action: act, number: num};
    do @(posedge clk); while (busy);
  endtask

  // Number field is don't-care on allocate; keep it noisy.
  task automatic alloc_word();
    send_word(ACT_ALLOC, num_t'($urandom));
  endtask

  task automatic release_word(input num_t num);
    send_word(ACT_RELEASE, num);
  endtask

  // Stop sending and wait until every outstanding word has its result.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  // Register write only with the block idle.
  task automatic set_start_number(input num_t val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pull a random previously granted id out of the pool.
  function automatic num_t take_held();
    int   k;
    num_t id;
    k = $urandom_range(held_ids.size() - 1);
    id = held_ids[k];
    held_ids[k] = held_ids[held_ids.size() - 1];
    held_ids.pop_back();
    return id;
  endfunction

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int   ph;
    int   sel;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- Directed: pointer edge cases and release corner cases ----
    // Start number is still at its reset value of 1.
    alloc_word();                           // pointer 1 -> 2
    send_word(ACT_ALLOC, '1);               // number field all ones, ignored
    release_word('0);                       // release of zero does nothing
    release_word(num_t'(2));
    release_word(num_t'(2));                // already free, stays free
    release_word(num_t'(MAX_NUMBER));       // top id, never granted so far
    alloc_word();
    set_start_number(num_t'(2));            // search lands on used ids, must skip
    alloc_word();
    set_start_number('0);                   // out-of-range pointer becomes 1
    alloc_word();
    set_start_number(num_t'(MAX_NUMBER));   // pointer at the top wraps to 1
    alloc_word();
    set_start_number(num_t'(MAX_NUMBER - 1));
    alloc_word();                           // grants the top id
    alloc_word();                           // pointer wraps, skips low used ids
    set_start_number(num_t'(MAX_NUMBER - 1));
    alloc_word();                           // top id used: search wraps to the bottom
    release_word(num_t'(15'h5555));         // alternating bit patterns
    release_word(num_t'(15'h2AAA));
    release_word(num_t'(1));
    alloc_word();

    // ---- A run of used ids spanning several rows ----
    // Allocations that restart just below the run must scan across it.
    set_start_number(num_t'(100));
    repeat (70) alloc_word();               // grants 101..170
    set_start_number(num_t'(100));
    repeat (3) alloc_word();                // each one crosses the run

    // ---- Random traffic in phases, with sender idling in some of them ----
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_start_number(num_t'($urandom_range(1, MAX_NUMBER)));
        1: set_start_number('0);
        2: set_start_number(num_t'(MAX_NUMBER));
        default: set_start_number(num_t'($urandom));
      endcase
      idle_pct = (ph == 1) ? 67 : (ph == 3) ? 29 : 0;
      repeat (330) begin
        sel = $urandom_range(99);
        if (sel < 50)
          alloc_word();
        else if (sel < 80 && held_ids.size() != 0)
          release_word(take_held());
        else if (sel < 84)
          release_word('0);
        else if (sel < 99)
          release_word(num_t'($urandom));
        else
          drain();                          // sender waits for all results
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
